// ===== hdl/fci_pkg.sv =====
`default_nettype none

package fci_pkg;

    localparam int FRAC_BITS = 16;

    localparam int GAIN_W  = 18;
    localparam int EPS_W   = 31;
    localparam int SCALE_W = 31;
    localparam int MU_W    = 21;
    localparam int PADDR_W = 3;

    // mu * g_n: 21 bits by a positive 31-bit normal impulse
    localparam int MG_W = MU_W + 31;
    localparam int MG_H = MG_W / 2;

    localparam logic [GAIN_W-1:0] GAIN_MAX   = GAIN_W'(131072);
    localparam logic [GAIN_W-1:0] GAIN_RESET = GAIN_W'(65536);
    localparam logic [EPS_W-1:0]  EPS_RESET  = EPS_W'(66);

    localparam int QDEPTH = 4;

    // register index, taken from paddr[2]
    localparam logic REG_GAIN = 1'b0;
    localparam logic REG_EPS  = 1'b1;

    typedef enum logic [1:0] {
        CONE_SEP  = 2'd0,
        CONE_IN   = 2'd1,
        CONE_PROJ = 2'd2
    } t_cone;

    typedef struct packed {
        logic signed [31:0]  vel_t1;
        logic signed [31:0]  vel_t2;
        logic signed [31:0]  vel_n;
        logic signed [31:0]  imp_t1;
        logic signed [31:0]  imp_t2;
        logic signed [31:0]  imp_n;
        logic [SCALE_W-1:0]  scale_t;
        logic [SCALE_W-1:0]  scale_n;
        logic [MU_W-1:0]     friction_coef;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] new_t1;
        logic signed [31:0] new_t2;
        logic signed [31:0] new_n;
        t_cone              cone_case;
        logic               saturated;
    } t_out_item;

    // classified item handed from front to back
    typedef struct packed {
        logic signed [31:0] g1;
        logic signed [31:0] g2;
        logic signed [31:0] gn;
        logic signed [31:0] vt1;
        logic signed [31:0] vt2;
        logic [MG_W-1:0]    mg;
        t_cone              kase;
        logic               sat_in;
        logic               fn;
    } t_mid;

    function automatic logic [31:0] mag32(input logic signed [31:0] v);
        return v[31] ? 32'(-v) : 32'(v);
    endfunction

endpackage

`default_nettype wire

// ===== hdl/fci_front.sv =====
`default_nettype none

module fci_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  fci_pkg::t_in_item i_item,
    input  logic [fci_pkg::GAIN_W-1:0] i_gain,
    output logic              o_full,
    output logic              o_valid,
    output fci_pkg::t_mid     o_mid,
    input  logic              i_mid_full
);
    import fci_pkg::*;

    localparam int SW = 64 - FRAC_BITS;
    localparam int GW = SW + 2;
    localparam int CW = (2 * MG_W > 64 + 2 * FRAC_BITS) ? 2 * MG_W : 64 + 2 * FRAC_BITS;

    function automatic logic [SW-1:0] step_round(input logic [63:0] m);
        logic [63:0] t;
        t = m + (64'(1) << (FRAC_BITS - 1));
        return t[63:FRAC_BITS];
    endfunction

    function automatic logic signed [GW-1:0] relax_g(input logic signed [31:0] imp,
                                                      input logic signed [31:0] v,
                                                      input logic [SW-1:0] s);
        logic signed [GW-1:0] iw;
        logic signed [GW-1:0] sw;
        iw = $signed({{(GW-32){imp[31]}}, imp});
        sw = $signed({2'b00, s});
        return v[31] ? iw + sw : iw - sw;
    endfunction

    // {clamped, value}
    function automatic logic [32:0] sat32(input logic signed [GW-1:0] g);
        if (g[GW-1:31] == '0 || g[GW-1:31] == '1) begin
            return {1'b0, g[31:0]};
        end
        return g[GW-1] ? {1'b1, 32'h8000_0000} : {1'b1, 32'h7FFF_FFFF};
    endfunction

    logic [3:0] r_v;
    logic       en;

    assign en     = !r_v[3] || !i_mid_full;
    assign o_full = !en;

    // stage 1: c = round(omega * Dinv)
    logic [48:0] p_t, p_n;
    logic [31:0] r1_ct, r1_cn;
    t_in_item    r1_item;

    assign p_t = 49'(i_gain) * 49'(i_item.scale_t) + 49'(32768);
    assign p_n = 49'(i_gain) * 49'(i_item.scale_n) + 49'(32768);

    // stage 2: relaxed impulse, unsaturated
    logic [63:0] m1, m2, mn;
    logic signed [GW-1:0] r2_g1, r2_g2, r2_gn;
    logic signed [31:0]   r2_vt1, r2_vt2;
    logic [MU_W-1:0]      r2_mu;

    assign m1 = 64'(r1_ct) * 64'(mag32(r1_item.vel_t1));
    assign m2 = 64'(r1_ct) * 64'(mag32(r1_item.vel_t2));
    assign mn = 64'(r1_cn) * 64'(mag32(r1_item.vel_n));

    // stage 3: saturate, mu*g_n and tangential squares
    logic [32:0] s1, s2, sn;
    logic signed [31:0] r3_g1, r3_g2, r3_gn, r3_vt1, r3_vt2;
    logic        r3_ft, r3_fn;
    logic [MG_W-1:0] r3_mg;
    logic [63:0] r3_sq1, r3_sq2;

    assign s1 = sat32(r2_g1);
    assign s2 = sat32(r2_g2);
    assign sn = sat32(r2_gn);

    // stage 4: |g_t|^2 and partial products of (mu*g_n)^2
    logic signed [31:0] r4_g1, r4_g2, r4_gn, r4_vt1, r4_vt2;
    logic        r4_ft, r4_fn;
    logic [MG_W-1:0] r4_mg;
    logic [63:0] r4_bsq;
    logic [2*MG_H-1:0] r4_pll, r4_plh;
    logic [2*(MG_W-MG_H)-1:0] r4_phh;

    logic [CW-1:0] lhs, rhs;
    logic          in_cone;

    assign lhs = CW'({r4_bsq, {(2*FRAC_BITS){1'b0}}});
    assign rhs = (CW'(r4_phh) << (2 * MG_H)) + (CW'(r4_plh) << (MG_H + 1)) + CW'(r4_pll);
    assign in_cone = lhs <= rhs;

    always_comb begin
        o_mid.g1     = r4_g1;
        o_mid.g2     = r4_g2;
        o_mid.gn     = r4_gn;
        o_mid.vt1    = r4_vt1;
        o_mid.vt2    = r4_vt2;
        o_mid.mg     = r4_mg;
        o_mid.sat_in = r4_ft || r4_fn;
        o_mid.fn     = r4_fn;
        if (r4_gn[31] || r4_gn == '0) begin
            o_mid.kase = CONE_SEP;
        end else if (in_cone) begin
            o_mid.kase = CONE_IN;
        end else begin
            o_mid.kase = CONE_PROJ;
        end
    end

    assign o_valid = r_v[3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (en) begin
            r_v <= {r_v[2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_ct   <= p_t[47:16];
            r1_cn   <= p_n[47:16];
            r1_item <= i_item;

            r2_g1  <= relax_g(r1_item.imp_t1, r1_item.vel_t1, step_round(m1));
            r2_g2  <= relax_g(r1_item.imp_t2, r1_item.vel_t2, step_round(m2));
            r2_gn  <= relax_g(r1_item.imp_n, r1_item.vel_n, step_round(mn));
            r2_vt1 <= r1_item.vel_t1;
            r2_vt2 <= r1_item.vel_t2;
            r2_mu  <= r1_item.friction_coef;

            r3_g1  <= s1[31:0];
            r3_g2  <= s2[31:0];
            r3_gn  <= sn[31:0];
            r3_ft  <= s1[32] || s2[32];
            r3_fn  <= sn[32];
            r3_mg  <= MG_W'(r2_mu) * MG_W'(sn[30:0]);
            r3_sq1 <= 64'(mag32(s1[31:0])) * 64'(mag32(s1[31:0]));
            r3_sq2 <= 64'(mag32(s2[31:0])) * 64'(mag32(s2[31:0]));
            r3_vt1 <= r2_vt1;
            r3_vt2 <= r2_vt2;

            r4_g1  <= r3_g1;
            r4_g2  <= r3_g2;
            r4_gn  <= r3_gn;
            r4_ft  <= r3_ft;
            r4_fn  <= r3_fn;
            r4_mg  <= r3_mg;
            r4_vt1 <= r3_vt1;
            r4_vt2 <= r3_vt2;
            r4_bsq <= r3_sq1 + r3_sq2;
            r4_pll <= (2*MG_H)'(r3_mg[MG_H-1:0]) * (2*MG_H)'(r3_mg[MG_H-1:0]);
            r4_plh <= (2*MG_H)'(r3_mg[MG_H-1:0]) * (2*MG_H)'(r3_mg[MG_W-1:MG_H]);
            r4_phh <= (2*(MG_W-MG_H))'(r3_mg[MG_W-1:MG_H])
                      * (2*(MG_W-MG_H))'(r3_mg[MG_W-1:MG_H]);
        end
    end

endmodule

`default_nettype wire

// ===== hdl/fci_queue.sv =====
`default_nettype none

module fci_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  fci_pkg::t_mid i_data,
    output logic          o_full,
    output logic          o_empty,
    output fci_pkg::t_mid o_data,
    input  logic          i_pop
);
    import fci_pkg::*;

    localparam int AW = $clog2(QDEPTH);

    t_mid           r_mem [QDEPTH];
    logic [AW-1:0]  r_wr, r_rd;
    logic [AW:0]    r_cnt;
    logic           wr, rd;

    assign o_full  = r_cnt == (AW+1)'(QDEPTH);
    assign o_empty = r_cnt == '0;
    assign o_data  = r_mem[r_rd];
    assign wr      = i_push && !o_full;
    assign rd      = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (wr) begin
                r_wr <= r_wr + AW'(1);
            end
            if (rd) begin
                r_rd <= r_rd + AW'(1);
            end
            if (wr && !rd) begin
                r_cnt <= r_cnt + (AW+1)'(1);
            end else if (rd && !wr) begin
                r_cnt <= r_cnt - (AW+1)'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/fci_back.sv =====
`default_nettype none

module fci_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_mid_valid,
    input  fci_pkg::t_mid      i_mid,
    output logic               o_mid_pop,
    input  logic [fci_pkg::EPS_W-1:0] i_eps,
    output logic               o_valid,
    output fci_pkg::t_out_item o_result,
    input  logic               i_pop
);
    import fci_pkg::*;

    localparam int PPW = (MG_W - MG_H) + 32;
    localparam int PW  = MG_W + 32;
    localparam int RS  = FRAC_BITS + 30;

    localparam int K_SUM = 1;
    localparam int K_NRM = 2;
    localparam int NRM_N = 5;
    localparam int K_SQ  = K_NRM + NRM_N;
    localparam int SQ_N  = 32;
    localparam int K_DP  = K_SQ + SQ_N;
    localparam int K_DV  = K_DP + 1;
    localparam int DV_N  = 32;
    localparam int K_PP  = K_DV + DV_N;
    localparam int K_OUT = K_PP + 1;
    localparam int NB    = K_OUT + 1;

    typedef struct packed {
        t_mid        m;
        logic [63:0] sq1;
        logic [63:0] sq2;
        logic [63:0] sqe;
        logic [63:0] n;
        logic [4:0]  hs;
        logic [33:0] rem;
        logic [31:0] root;
        logic [63:0] num1;
        logic [63:0] num2;
        logic [32:0] dr1;
        logic [32:0] dr2;
        logic [31:0] q1;
        logic [31:0] q2;
        logic [PPW-1:0] pl1;
        logic [PPW-1:0] ph1;
        logic [PPW-1:0] pl2;
        logic [PPW-1:0] ph2;
        t_out_item   res;
    } t_bk;

    // {clamped, value}: magnitude placed opposite to the velocity sign
    function automatic logic [32:0] place(input logic signed [31:0] vt,
                                          input logic [PW-1:0] mag);
        if (!vt[31] && vt != '0) begin
            if (mag > PW'(64'h8000_0000)) begin
                return {1'b1, 32'h8000_0000};
            end
            return {1'b0, 32'(-mag[31:0])};
        end
        if (mag > PW'(64'h7FFF_FFFF)) begin
            return {1'b1, 32'h7FFF_FFFF};
        end
        return {1'b0, mag[31:0]};
    endfunction

    function automatic logic [PW-1:0] rnd_mag(input logic [PPW-1:0] ph,
                                              input logic [PPW-1:0] pl);
        logic [PW-1:0] p;
        p = (PW'(ph) << MG_H) + PW'(pl) + (PW'(1) << (RS - 1));
        return p >> RS;
    endfunction

    logic [NB-1:0] r_v;
    t_bk           r_p [NB];
    t_bk           n_p [NB];
    logic          en;

    assign en        = !r_v[NB-1] || i_pop;
    assign o_mid_pop = en && i_mid_valid;
    assign o_valid   = r_v[NB-1];
    assign o_result  = r_p[NB-1].res;

    always_comb begin
        n_p[0]     = 'x;
        n_p[0].m   = i_mid;
        n_p[0].sq1 = 64'(mag32(i_mid.vt1)) * 64'(mag32(i_mid.vt1));
        n_p[0].sq2 = 64'(mag32(i_mid.vt2)) * 64'(mag32(i_mid.vt2));
        n_p[0].sqe = 64'(i_eps) * 64'(i_eps);
    end

    for (genvar k = 1; k < NB; k++) begin : g_stage
        if (k == K_SUM) begin : g_sum
            always_comb begin
                n_p[k]      = r_p[k-1];
                n_p[k].n    = r_p[k-1].sq1 + r_p[k-1].sq2 + r_p[k-1].sqe;
                n_p[k].hs   = '0;
                n_p[k].rem  = '0;
                n_p[k].root = '0;
            end
        end else if (k < K_SQ) begin : g_nrm
            // even shifts of 32, 16, 8, 4, 2 leave bit 62 or 63 set
            localparam int SH = 64 >> (k - K_NRM + 1);
            always_comb begin
                n_p[k] = r_p[k-1];
                if (r_p[k-1].n[63 -: SH] == '0) begin
                    n_p[k].n  = r_p[k-1].n << SH;
                    n_p[k].hs = r_p[k-1].hs + 5'(SH / 2);
                end
            end
        end else if (k < K_DP) begin : g_sqrt
            localparam int J = k - K_SQ;
            always_comb begin
                logic [33:0] t;
                logic [33:0] trial;
                n_p[k] = r_p[k-1];
                t      = {r_p[k-1].rem[31:0], r_p[k-1].n[63-2*J -: 2]};
                trial  = {r_p[k-1].root, 2'b01};
                if (t >= trial) begin
                    n_p[k].rem  = t - trial;
                    n_p[k].root = {r_p[k-1].root[30:0], 1'b1};
                end else begin
                    n_p[k].rem  = t;
                    n_p[k].root = {r_p[k-1].root[30:0], 1'b0};
                end
            end
        end else if (k == K_DP) begin : g_dprep
            always_comb begin
                logic [63:0] h;
                n_p[k]      = r_p[k-1];
                h           = 64'(r_p[k-1].root >> 1);
                n_p[k].num1 = (64'(mag32(r_p[k-1].m.vt1)) << (30 + r_p[k-1].hs)) + h;
                n_p[k].num2 = (64'(mag32(r_p[k-1].m.vt2)) << (30 + r_p[k-1].hs)) + h;
                n_p[k].dr1  = {1'b0, n_p[k].num1[63:32]};
                n_p[k].dr2  = {1'b0, n_p[k].num2[63:32]};
                n_p[k].q1   = '0;
                n_p[k].q2   = '0;
            end
        end else if (k < K_PP) begin : g_div
            localparam int J = k - K_DV;
            always_comb begin
                logic [32:0] t1;
                logic [32:0] t2;
                logic [32:0] d;
                n_p[k] = r_p[k-1];
                d      = {1'b0, r_p[k-1].root};
                t1     = {r_p[k-1].dr1[31:0], r_p[k-1].num1[31-J]};
                t2     = {r_p[k-1].dr2[31:0], r_p[k-1].num2[31-J]};
                if (t1 >= d) begin
                    n_p[k].dr1 = t1 - d;
                    n_p[k].q1  = {r_p[k-1].q1[30:0], 1'b1};
                end else begin
                    n_p[k].dr1 = t1;
                    n_p[k].q1  = {r_p[k-1].q1[30:0], 1'b0};
                end
                if (t2 >= d) begin
                    n_p[k].dr2 = t2 - d;
                    n_p[k].q2  = {r_p[k-1].q2[30:0], 1'b1};
                end else begin
                    n_p[k].dr2 = t2;
                    n_p[k].q2  = {r_p[k-1].q2[30:0], 1'b0};
                end
            end
        end else if (k == K_PP) begin : g_pp
            always_comb begin
                n_p[k]     = r_p[k-1];
                n_p[k].pl1 = PPW'(r_p[k-1].m.mg[MG_H-1:0]) * PPW'(r_p[k-1].q1);
                n_p[k].ph1 = PPW'(r_p[k-1].m.mg[MG_W-1:MG_H]) * PPW'(r_p[k-1].q1);
                n_p[k].pl2 = PPW'(r_p[k-1].m.mg[MG_H-1:0]) * PPW'(r_p[k-1].q2);
                n_p[k].ph2 = PPW'(r_p[k-1].m.mg[MG_W-1:MG_H]) * PPW'(r_p[k-1].q2);
            end
        end else begin : g_out
            always_comb begin
                logic [32:0] c1;
                logic [32:0] c2;
                n_p[k] = r_p[k-1];
                c1     = place(r_p[k-1].m.vt1, rnd_mag(r_p[k-1].ph1, r_p[k-1].pl1));
                c2     = place(r_p[k-1].m.vt2, rnd_mag(r_p[k-1].ph2, r_p[k-1].pl2));
                n_p[k].res.cone_case = r_p[k-1].m.kase;
                case (r_p[k-1].m.kase)
                    CONE_IN: begin
                        n_p[k].res.new_t1    = r_p[k-1].m.g1;
                        n_p[k].res.new_t2    = r_p[k-1].m.g2;
                        n_p[k].res.new_n     = r_p[k-1].m.gn;
                        n_p[k].res.saturated = r_p[k-1].m.sat_in;
                    end
                    CONE_PROJ: begin
                        n_p[k].res.new_t1    = c1[31:0];
                        n_p[k].res.new_t2    = c2[31:0];
                        n_p[k].res.new_n     = r_p[k-1].m.gn;
                        n_p[k].res.saturated = c1[32] || c2[32] || r_p[k-1].m.fn;
                    end
                    default: begin
                        n_p[k].res.new_t1    = '0;
                        n_p[k].res.new_t2    = '0;
                        n_p[k].res.new_n     = '0;
                        n_p[k].res.saturated = 1'b0;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (en) begin
            r_v <= {r_v[NB-2:0], i_mid_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < NB; k++) begin
                r_p[k] <= n_p[k];
            end
        end
    end

endmodule

`default_nettype wire

// ===== hdl/friction_cone_impulse_update.sv =====
// Friction cone impulse update: one contact's relaxation and cone projection.
// Throughput: one item per cycle while results are popped; the back end
// holds the 32-step square-root and 32-step divide pipelines.
// The front end (4 stages) runs on into a 4-entry queue while results stall.
// Reset (synchronous, active low) empties all stages and the queue and loads
// relaxation_gain = 1.0 and velocity_epsilon = 66.
`default_nettype none

module friction_cone_impulse_update (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // item input, queue style
    input  logic               push,
    input  fci_pkg::t_in_item  i_item,
    output logic               full,
    // result output, queue style
    output logic               empty,
    input  logic               pop,
    output fci_pkg::t_out_item o_result,
    // configuration
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [fci_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    import fci_pkg::*;

    logic [GAIN_W-1:0] r_gain;
    logic [EPS_W-1:0]  r_eps;
    logic [GAIN_W-1:0] gain_eff;
    logic [EPS_W-1:0]  eps_eff;
    logic              cfg_wr;

    // front -> queue -> back
    logic f_valid, q_full, q_empty, q_pop;
    t_mid f_mid, q_data;
    logic empty_n;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain <= GAIN_RESET;
            r_eps  <= EPS_RESET;
        end else if (cfg_wr) begin
            case (paddr[2])
                REG_GAIN: r_gain <= pwdata[GAIN_W-1:0];
                REG_EPS:  r_eps  <= pwdata[EPS_W-1:0];
                default:  ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_GAIN: prdata = 32'(r_gain);
            REG_EPS:  prdata = 32'(r_eps);
            default:  prdata = '0;
        endcase
    end

    // gain clamps at 2.0, a zero epsilon acts as one LSB
    assign gain_eff = (r_gain > GAIN_MAX) ? GAIN_MAX : r_gain;
    assign eps_eff  = (r_eps == '0) ? EPS_W'(1) : r_eps;

    // front: relaxed impulse, saturation, cone classification
    fci_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (push),
        .i_item     (i_item),
        .i_gain     (gain_eff),
        .o_full     (full),
        .o_valid    (f_valid),
        .o_mid      (f_mid),
        .i_mid_full (q_full)
    );

    // decouples the front from result stalls
    fci_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_valid),
        .i_data  (f_mid),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_data  (q_data),
        .i_pop   (q_pop)
    );

    // back: normalize, sqrt, divide, scale by mu*g_n, select result
    fci_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_mid_valid (!q_empty),
        .i_mid       (q_data),
        .o_mid_pop   (q_pop),
        .i_eps       (eps_eff),
        .o_valid     (empty_n),
        .o_result    (o_result),
        .i_pop       (pop)
    );

    assign empty = !empty_n;

endmodule

`default_nettype wire

// ===== hdl/fci_checker.sv =====
`default_nettype none

module fci_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               full,
    input logic               empty,
    input logic               pop,
    input fci_pkg::t_out_item o_result
);
    import fci_pkg::*;

    // reset leaves no result pending and input open
    a_reset: assert property (@(posedge i_clk) !i_rst_n |=> empty && !full)
        else $error("reset did not clear pipeline");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && !pop |=> !empty && $stable(o_result))
        else $error("stalled result changed");

    a_sep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && o_result.cone_case == CONE_SEP |->
        o_result.new_t1 == 0 && o_result.new_t2 == 0 && o_result.new_n == 0
        && !o_result.saturated)
        else $error("separated contact with nonzero impulse");

    a_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && o_result.cone_case != CONE_SEP |-> $signed(o_result.new_n) > 0)
        else $error("contact in cone with nonpositive normal impulse");

endmodule

bind friction_cone_impulse_update fci_checker u_chk (.*);

`default_nettype wire

// ===== tb/tb.sv =====
`default_nettype none

// Checks friction_cone_impulse_update against a bit-exact predictor of the
// relaxation step and the cone projection, with random idling on both sides
// of the item queues and configuration changes between phases.
module tb;
    import fci_pkg::*;

    typedef logic [63:0]  u64;
    typedef logic [127:0] u128;

    localparam int HALT_CYCLES = 600000;
    localparam int DRAIN_CYCLES = 120;   // extra wait for stray impulses after the queues drain
    localparam int LONG_HOLD = 2000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    logic      push = 1'b0;
    t_in_item  i_item = '0;
    logic      full;
    logic      empty;
    logic      pop = 1'b0;
    t_out_item o_result;

    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [PADDR_W-1:0] paddr = '0;
    logic [31:0]        pwdata = '0;
    logic [31:0]        prdata;
    logic               pready;

    friction_cone_impulse_update dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .push     (push),
        .i_item   (i_item),
        .full     (full),
        .empty    (empty),
        .pop      (pop),
        .o_result (o_result),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // shadow of the configuration registers
    logic [GAIN_W-1:0] gain_reg = GAIN_RESET;
    logic [EPS_W-1:0]  eps_reg  = EPS_RESET;

    t_in_item  contact_q[$];       // contacts waiting to be offered
    t_out_item impulse_q[$];       // predicted impulses, oldest first
    int        mismatches = 0;
    int        cycles = 0;
    int        impulses_seen = 0;

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // ---------------------------------------------------------------
    // Predictor
    // ---------------------------------------------------------------
    function automatic u64 mag(input longint v);
        return v < 0 ? u64'(-v) : u64'(v);
    endfunction

    function automatic longint clamp32(input longint v, inout bit hit);
        if (v > 64'sd2147483647) begin
            hit = 1'b1;
            return 64'sd2147483647;
        end
        if (v < -64'sd2147483648) begin
            hit = 1'b1;
            return -64'sd2147483648;
        end
        return v;
    endfunction

    // g = gamma - sign(v) * round(round(omega*Dinv) * |v|)
    function automatic longint relax_step(input logic signed [31:0] imp,
                                          input logic signed [31:0] vel,
                                          input logic [30:0] scale,
                                          input u64 gain, inout bit hit);
        u64 c, s;
        longint g;
        c = (gain * u64'(scale) + 64'd32768) >> 16;
        s = (c * mag(longint'(vel)) + (u64'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
        g = vel < 0 ? longint'(imp) + longint'(s) : longint'(imp) - longint'(s);
        return clamp32(g, hit);
    endfunction

    function automatic u64 floor_sqrt(input u64 n);
        u64 r, b;
        r = 0;
        b = u64'(1) << 62;
        while (b > n) b = b >> 2;
        while (b != 0) begin
            if (n >= r + b) begin
                n = n - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // one tangential component pushed onto the cone surface
    function automatic longint cone_component(input longint vt, input u64 mg,
                                              input u64 d, input int hs,
                                              inout bit hit);
        u64 num, u, m;
        u128 p;
        num = mag(vt);
        num = num << (30 + hs);
        u = (num + d / 2) / d;
        p = u128'(mg) * u128'(u);
        m = u64'((p + (u128'(1) << (FRAC_BITS + 29))) >> (FRAC_BITS + 30));
        if (vt > 0) begin
            if (m > 64'd2147483648) begin
                hit = 1'b1;
                return -64'sd2147483648;
            end
            return -longint'(m);
        end
        if (m > 64'd2147483647) begin
            hit = 1'b1;
            return 64'sd2147483647;
        end
        return longint'(m);
    endfunction

    function automatic t_out_item predict_impulse(input t_in_item c);
        t_out_item r;
        u64 gain, eps, mu, bsq, mg, n2, d;
        u128 lhs, rhs;
        longint g1, g2, gn, v1, v2;
        bit ft, fn, fp;
        int sh;
        ft = 0; fn = 0; fp = 0;
        gain = gain_reg > GAIN_MAX ? u64'(GAIN_MAX) : u64'(gain_reg);
        eps = eps_reg == 0 ? 64'd1 : u64'(eps_reg);
        mu = u64'(c.friction_coef);
        g1 = relax_step(c.imp_t1, c.vel_t1, c.scale_t, gain, ft);
        g2 = relax_step(c.imp_t2, c.vel_t2, c.scale_t, gain, ft);
        gn = relax_step(c.imp_n, c.vel_n, c.scale_n, gain, fn);
        r = '0;
        r.cone_case = CONE_SEP;
        if (gn > 0) begin
            bsq = mag(g1) * mag(g1) + mag(g2) * mag(g2);
            lhs = u128'(bsq) << (2 * FRAC_BITS);
            mg = mu * u64'(gn);
            rhs = u128'(mg) * u128'(mg);
            r.new_n = 32'(gn);
            if (lhs <= rhs) begin
                r.cone_case = CONE_IN;
                r.new_t1 = 32'(g1);
                r.new_t2 = 32'(g2);
                r.saturated = ft | fn;
            end else begin
                v1 = longint'(c.vel_t1);
                v2 = longint'(c.vel_t2);
                n2 = mag(v1) * mag(v1) + mag(v2) * mag(v2) + eps * eps;
                sh = 0;
                while (n2[63:62] == 2'b00) begin
                    n2 = n2 << 2;
                    sh += 2;
                end
                d = floor_sqrt(n2);
                r.cone_case = CONE_PROJ;
                r.new_t1 = 32'(cone_component(v1, mg, d, sh / 2, fp));
                r.new_t2 = 32'(cone_component(v2, mg, d, sh / 2, fp));
                r.saturated = fp | fn;
            end
        end
        return r;
    endfunction

    // ---------------------------------------------------------------
    // Stimulus helpers
    // ---------------------------------------------------------------
    function automatic t_in_item contact(input int vt1, input int vt2, input int vn,
                                         input int it1, input int it2, input int in_,
                                         input int st, input int sn, input int mu);
        t_in_item c;
        c.vel_t1 = vt1; c.vel_t2 = vt2; c.vel_n = vn;
        c.imp_t1 = it1; c.imp_t2 = it2; c.imp_n = in_;
        c.scale_t = 31'(st); c.scale_n = 31'(sn); c.friction_coef = 21'(mu);
        return c;
    endfunction

    function automatic int scaled_rand(input int max_bits);
        int v;
        v = int'($urandom) >>> (31 - $urandom_range(max_bits, 1));
        return v;
    endfunction

    // mostly plausible contacts, some raw bit noise
    function automatic t_in_item random_contact();
        t_in_item c;
        if ($urandom_range(9) < 2) begin
            c = $bits(t_in_item)'({$urandom, $urandom, $urandom, $urandom, $urandom,
                                   $urandom, $urandom, $urandom, $urandom});
        end else begin
            c.vel_t1 = scaled_rand(24);
            c.vel_t2 = ($urandom_range(7) == 0) ? 0 : scaled_rand(24);
            c.vel_n = scaled_rand(22);
            c.imp_t1 = scaled_rand(24);
            c.imp_t2 = scaled_rand(24);
            c.imp_n = ($urandom_range(5) == 0) ? -scaled_rand(22) : $urandom_range(1 << 24);
            c.scale_t = 31'($urandom_range(1 << 18));
            c.scale_n = 31'($urandom_range(1 << 18));
            c.friction_coef = 21'(($urandom_range(15) == 0) ? $urandom
                                                            : $urandom_range(1 << 17));
        end
        return c;
    endfunction

    task automatic write_reg(input logic idx, input logic [31:0] value);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= PADDR_W'({idx, 2'b00});
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (idx == REG_GAIN) gain_reg = GAIN_W'(value);
        else eps_reg = EPS_W'(value);
    endtask

    task automatic wait_idle();
        while (contact_q.size() != 0 || push || impulse_q.size() != 0)
            @(posedge i_clk);
    endtask

    // ---------------------------------------------------------------
    // Sequencer: directed contacts, then random phases under new settings
    // ---------------------------------------------------------------
    initial begin
        logic [31:0] gains[6];
        logic [31:0] epss[6];
        gains = '{32'd65536, 32'd0, 32'd131072, 32'd262143, 32'd98304, 32'd0};
        epss  = '{32'd66, 32'd1, 32'd2147483647, 32'd0, 32'd1000, 32'd0};
        gains[5] = $urandom_range(262143);
        epss[5] = $urandom & 32'h7fffffff;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed contacts under reset settings
        contact_q.push_back(contact(0, 0, 0, 0, 0, 0, 0, 0, 0));
        contact_q.push_back(contact(0, 0, 0, 0, 0, -1000 << 16, 0, 0, 1 << 16));
        contact_q.push_back(contact(0, 0, 0, 1 << 16, 0, 10 << 16, 0, 0, 1 << 16));
        contact_q.push_back(contact(3 << 16, -4 << 16, 0, 10 << 16, 2 << 16, 1 << 16,
                                    0, 0, 32'h8000));
        // zero tangential velocity while projecting
        contact_q.push_back(contact(0, 0, 0, 10 << 16, -7 << 16, 1 << 16, 0, 0, 32'h8000));
        contact_q.push_back(contact(0, 5 << 16, 0, 10 << 16, 0, 1 << 16, 0, 0, 32'h8000));
        // clamping inside the cone
        contact_q.push_back(contact(32'h80000000, 0, 0, 32'h7fffffff, 0, 32'h7fff0000,
                                    32'h7fffffff, 0, 32'h1fffff));
        // maximal impulses at full friction stay inside the cone
        contact_q.push_back(contact(1, -1, 0, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                                    0, 0, 32'h1fffff));
        // normal impulse clamps
        contact_q.push_back(contact(0, 0, 32'h80000000, 0, 0, 32'h7fffffff,
                                    0, 32'h7fffffff, 1 << 16));
        contact_q.push_back(contact(32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                                    32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                                    32'h7fffffff, 32'h7fffffff, 32'h1fffff));
        contact_q.push_back(contact(32'h80000000, 32'h80000000, 32'h80000000,
                                    32'h80000000, 32'h80000000, 32'h80000000,
                                    32'h7fffffff, 32'h7fffffff, 32'h1fffff));
        contact_q.push_back(contact(32'h80000000, 32'h80000000, 32'h80000000,
                                    32'h80000000, 32'h80000000, 32'h7fffffff,
                                    0, 0, 32'h1fffff));
        // zero friction: tangential impulse nonzero projects to zero, zero stays inside
        contact_q.push_back(contact(2 << 16, 1 << 16, 0, 3 << 16, 0, 4 << 16, 0, 0, 0));
        contact_q.push_back(contact(0, 0, 0, 0, 0, 4 << 16, 0, 0, 0));
        // exactly on the cone edge
        contact_q.push_back(contact(0, 0, 0, 3 << 16, 4 << 16, 5 << 16, 0, 0, 1 << 16));
        contact_q.push_back(contact(-2 << 16, 0, 1 << 16, 0, 0, 1, 1 << 16, 1 << 16, 1 << 16));

        for (int ph = 0; ph < 6; ph++) begin
            if (ph != 0) begin
                wait_idle();
                write_reg(REG_GAIN, gains[ph]);
                write_reg(REG_EPS, epss[ph]);
            end
            for (int k = 0; k < 190; k++) contact_q.push_back(random_contact());
        end
        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && impulse_q.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    // ---------------------------------------------------------------
    // Sender: offers queued contacts with random gaps
    // ---------------------------------------------------------------
    int  send_gap = 0;
    bit  send_quiet = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            push <= 1'b0;
        end else begin
            if (push && !full)
                impulse_q.push_back(predict_impulse(i_item));
            if (!push || !full) begin
                if (send_gap > 0) begin
                    send_gap <= send_gap - 1;
                    push <= 1'b0;
                end else if (contact_q.size() != 0) begin
                    i_item <= contact_q.pop_front();
                    push <= 1'b1;
                    if ($urandom_range(59) == 0) send_quiet <= !send_quiet;
                    send_gap <= send_quiet ? 0 : $urandom_range(17);
                end else begin
                    push <= 1'b0;
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // Long hold-off: once, after 100 impulses, the receiver stops for a
    // long stretch so the block fills and pushes back on the sender
    // ---------------------------------------------------------------
    int  hold_left = 0;
    bit  hold_done = 0;

    always @(posedge i_clk) begin
        if (!hold_done && impulses_seen == 100) begin
            hold_left <= LONG_HOLD;
            hold_done <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // ---------------------------------------------------------------
    // Receiver: checks each impulse, random stalls
    // ---------------------------------------------------------------
    int  recv_stall = 0;
    bit  recv_quiet = 0;

    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (pop && !empty) begin
                impulses_seen <= impulses_seen + 1;
                if (impulse_q.size() == 0) begin
                    mismatches <= mismatches + 1;
                    if (mismatches < 10)
                        $display("unexpected impulse %p", o_result);
                end else begin
                    want = impulse_q.pop_front();
                    if (o_result.new_t1 !== want.new_t1 || o_result.new_t2 !== want.new_t2
                        || o_result.new_n !== want.new_n
                        || o_result.cone_case !== want.cone_case
                        || o_result.saturated !== want.saturated) begin
                        mismatches <= mismatches + 1;
                        if (mismatches < 10)
                            $display("impulse %0d: expected %p got %p",
                                     impulses_seen, want, o_result);
                    end
                end
                pop <= 1'b0;
                if ($urandom_range(59) == 0) recv_quiet <= !recv_quiet;
                recv_stall <= recv_quiet ? 0 : $urandom_range(17);
            end else if (hold_left > 0) begin
                pop <= 1'b0;
            end else if (recv_stall > 0) begin
                recv_stall <= recv_stall - 1;
                pop <= 1'b0;
            end else begin
                pop <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > HALT_CYCLES) begin
            $display("status: fail");
            $finish;
        end
    end

endmodule

`default_nettype wire
